/* src/afr_pkg.sv */
`timescale 1ns / 1ps
// afr_pkg: sizes, frame constants and result codes of the api frame receiver
// no dependencies; used by api_frame_receiver

package afr_pkg;

    // frame buffer and payload sizes
    localparam int BUFFER_BYTES  = 64;
    localparam int PAYLOAD_BYTES = 16;

    // derived widths
    localparam int POS_W     = $clog2(BUFFER_BYTES + 1);
    localparam int ADDR_W    = $clog2(BUFFER_BYTES);
    localparam int RUN_BYTES = 8 + PAYLOAD_BYTES;
    localparam int IDX_W     = $clog2(RUN_BYTES);

    // frame format
    localparam logic [7:0] DELIM       = 8'h7E;
    localparam logic [7:0] TYPE_STATUS = 8'h8A;
    localparam logic [7:0] TYPE_RX64   = 8'h80;
    localparam logic [7:0] SUM_OK      = 8'hFF;
    localparam int RX64_OVERHEAD = 11;
    localparam int HDR_TRAIL     = 4;
    localparam int MAX_LEN       = BUFFER_BYTES - HDR_TRAIL;
    localparam int RX64_LEN      = RX64_OVERHEAD + PAYLOAD_BYTES;
    localparam int STATUS_LEN    = 2;
    localparam int ADDR_BYTES    = 8;
    localparam int ADDR_START    = 4;
    localparam int PAYLOAD_START = 14;

    // outcome codes
    localparam logic [2:0] OC_DATA     = 3'd0;
    localparam logic [2:0] OC_STATUS   = 3'd1;
    localparam logic [2:0] OC_SIZE     = 3'd2;
    localparam logic [2:0] OC_TYPE     = 3'd3;
    localparam logic [2:0] OC_BAD_SUM  = 3'd4;
    localparam logic [2:0] OC_LEN_REJ  = 3'd5;

endpackage

/* src/api_frame_receiver.sv */
`timescale 1ns / 1ps
// api_frame_receiver: byte-serial api frame parser, 64-bit address receive frames
// latency: a status or error outcome is loaded at the edge that accepts the byte that ends
//   or rejects the frame and is valid in the next cycle; a good data frame loads none there
// throughput: one byte per cycle while receiving and the output register is free; a good data frame then
//   streams 8+PAYLOAD_BYTES results, each through a frame buffer read, then an output load
// the registered frame buffer read paces the run; input is stalled during the run
// reset: synchronous active low, clears sequencer, position, length, sum, run index and output valid

module api_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_outcome,
    output logic [7:0] o_data_byte,
    output logic [4:0] o_byte_index,
    output logic       o_is_address,
    output logic [7:0] o_modem_status,
    output logic       o_last
);

    typedef enum logic [2:0] {
        ST_RECV  = 3'b001,
        ST_FETCH = 3'b010,
        ST_SEND  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [afr_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [afr_pkg::POS_W-1:0]  r_len, n_len;
    logic [7:0]                 r_len_hi, n_len_hi;
    logic [7:0]                 r_sum, n_sum;
    logic [7:0]                 r_type, n_type;
    logic [7:0]                 r_status, n_status;
    logic [afr_pkg::IDX_W-1:0]  r_idx, n_idx;

    logic       r_out_valid, n_out_valid;
    logic [2:0] r_outcome, n_outcome;
    logic [7:0] r_data, n_data;
    logic [4:0] r_index, n_index;
    logic       r_is_addr, n_is_addr;
    logic [7:0] r_mstat, n_mstat;
    logic       r_last, n_last;

    logic [7:0] r_mem [afr_pkg::BUFFER_BYTES];
    logic [7:0] r_rd_data;

    logic                      out_free;
    logic                      accept;
    logic [afr_pkg::POS_W-1:0] pos_inc;
    logic [15:0]               len16;
    logic [7:0]                sum_nxt;
    logic [7:0]                type_cur;
    logic                      frame_done;
    logic [afr_pkg::ADDR_W-1:0] rd_addr;
    logic                      run_end;

    // handshake
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !((r_state == ST_RECV) && out_free);
    assign accept   = i_valid && !o_stall;

    // frame buffer address for the run: address bytes, then payload bytes
    always_comb begin
        if (r_idx < afr_pkg::IDX_W'(afr_pkg::ADDR_BYTES)) begin
            rd_addr = afr_pkg::ADDR_W'(r_idx) + afr_pkg::ADDR_W'(afr_pkg::ADDR_START);
        end else begin
            rd_addr = afr_pkg::ADDR_W'(r_idx)
                    + afr_pkg::ADDR_W'(afr_pkg::PAYLOAD_START - afr_pkg::ADDR_BYTES);
        end
    end

    assign run_end  = (r_idx == afr_pkg::IDX_W'(afr_pkg::RUN_BYTES - 1));
    assign pos_inc  = r_pos + afr_pkg::POS_W'(1);
    assign len16    = {r_len_hi, i_rx_byte};
    assign sum_nxt  = r_sum + i_rx_byte;
    assign type_cur = (pos_inc == afr_pkg::POS_W'(afr_pkg::ADDR_START)) ? i_rx_byte : r_type;
    assign frame_done = (pos_inc == (r_len + afr_pkg::POS_W'(afr_pkg::HDR_TRAIL)))
                     || (pos_inc >= afr_pkg::POS_W'(afr_pkg::BUFFER_BYTES));

    // sequencer and result register
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_len       = r_len;
        n_len_hi    = r_len_hi;
        n_sum       = r_sum;
        n_type      = r_type;
        n_status    = r_status;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_outcome   = r_outcome;
        n_data      = r_data;
        n_index     = r_index;
        n_is_addr   = r_is_addr;
        n_mstat     = r_mstat;
        n_last      = r_last;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_RECV: begin
                if (accept) begin
                    n_pos = pos_inc;
                    if (pos_inc == afr_pkg::POS_W'(1)) begin
                        // hunt for the delimiter
                        if (i_rx_byte != afr_pkg::DELIM) begin
                            n_pos = '0;
                        end
                    end else if (pos_inc == afr_pkg::POS_W'(2)) begin
                        n_len_hi = i_rx_byte;
                    end else if (pos_inc == afr_pkg::POS_W'(3)) begin
                        // length check
                        if (len16 > 16'(afr_pkg::MAX_LEN)) begin
                            n_pos       = '0;
                            n_sum       = '0;
                            n_len       = '0;
                            n_out_valid = 1'b1;
                            n_outcome   = afr_pkg::OC_LEN_REJ;
                            n_data      = '0;
                            n_index     = '0;
                            n_is_addr   = 1'b0;
                            n_mstat     = '0;
                            n_last      = 1'b1;
                        end else begin
                            n_len = afr_pkg::POS_W'(len16);
                        end
                    end else begin
                        n_sum = sum_nxt;
                        if (pos_inc == afr_pkg::POS_W'(afr_pkg::ADDR_START)) begin
                            n_type = i_rx_byte;
                        end
                        if (pos_inc == afr_pkg::POS_W'(afr_pkg::ADDR_START + 1)) begin
                            n_status = i_rx_byte;
                        end
                        // frame end: classify
                        if (frame_done) begin
                            n_pos       = '0;
                            n_sum       = '0;
                            n_len       = '0;
                            n_out_valid = 1'b1;
                            n_data      = '0;
                            n_index     = '0;
                            n_is_addr   = 1'b0;
                            n_mstat     = '0;
                            n_last      = 1'b1;
                            if (sum_nxt != afr_pkg::SUM_OK) begin
                                n_outcome = afr_pkg::OC_BAD_SUM;
                            end else if (type_cur == afr_pkg::TYPE_STATUS
                                         && 16'(r_len) == 16'(afr_pkg::STATUS_LEN)) begin
                                n_outcome = afr_pkg::OC_STATUS;
                                n_mstat   = r_status;
                            end else if (type_cur == afr_pkg::TYPE_RX64) begin
                                if (16'(r_len) == 16'(afr_pkg::RX64_LEN)) begin
                                    n_out_valid = 1'b0;
                                    n_idx       = '0;
                                    n_state     = ST_FETCH;
                                end else begin
                                    n_outcome = afr_pkg::OC_SIZE;
                                end
                            end else begin
                                n_outcome = afr_pkg::OC_TYPE;
                            end
                        end
                    end
                end
            end
            ST_FETCH: begin
                n_state = ST_SEND;
            end
            ST_SEND: begin
                // load one address or payload byte
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_outcome   = afr_pkg::OC_DATA;
                    n_data      = r_rd_data;
                    n_index     = 5'(r_idx);
                    n_is_addr   = (r_idx < afr_pkg::IDX_W'(afr_pkg::ADDR_BYTES));
                    n_mstat     = '0;
                    n_last      = run_end;
                    if (run_end) begin
                        n_state = ST_RECV;
                    end else begin
                        n_idx   = r_idx + afr_pkg::IDX_W'(1);
                        n_state = ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = ST_RECV;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RECV;
            r_pos       <= '0;
            r_len       <= '0;
            r_sum       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_sum       <= n_sum;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_len_hi  <= n_len_hi;
        r_type    <= n_type;
        r_status  <= n_status;
        r_outcome <= n_outcome;
        r_data    <= n_data;
        r_index   <= n_index;
        r_is_addr <= n_is_addr;
        r_mstat   <= n_mstat;
        r_last    <= n_last;
    end

    // frame buffer, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (accept && r_pos < afr_pkg::POS_W'(afr_pkg::BUFFER_BYTES)) begin
            r_mem[r_pos[afr_pkg::ADDR_W-1:0]] <= i_rx_byte;
        end
        if (r_state == ST_FETCH) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // outputs
    assign o_valid        = r_out_valid;
    assign o_outcome      = r_outcome;
    assign o_data_byte    = r_data;
    assign o_byte_index   = r_index;
    assign o_is_address   = r_is_addr;
    assign o_modem_status = r_mstat;
    assign o_last         = r_last;

endmodule
